>>> sv/assert_macros.svh
// Assertion macros shared by the checker files of the downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define MPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define MPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mpd_pkg.sv
// Shared types and constants of the max-pooling downsampler.
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int PIX_W      = 16;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIDE   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] RST_SOURCE_SIDE = 13'd4096;
  localparam logic [CFG_DATA_W-1:0] RST_TARGET_SIDE = 13'd0;

  // Geometry sequencer states.
  typedef enum logic [1:0] {
    G_IDLE,
    G_CLAMP,
    G_LOAD,
    G_RUN
  } geom_state_t;

  // Which quotient the shared divider is working on.
  typedef enum logic [1:0] {
    STEP_OW,
    STEP_OH,
    STEP_CW,
    STEP_CH
  } geom_step_t;

endpackage

>>> sv/mpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/max_pool_downsampler.sv
// Top level of the streaming max-pooling elevation downsampler.
// A request that closes its window is registered into stage 1 on acceptance, and its result
// moves into the output register when stage 1 can go. Throughput: one request per cycle, set
// by the one read and one write of the column store per request, while no geometry update
// runs and the output is not held by out_stall. After reset and after every configuration
// write, in_stall stays high while a shared divider works out the output geometry.
`timescale 1ns / 1ps

module max_pool_downsampler
  import mpd_pkg::*;
#(
  parameter int MAX_SIDE = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      elevation,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      pooled_value,
  output logic                  row_end,
  output logic                  frame_end
);

  // Sizes run from 1 to MAX_SIDE; positions and column-store addresses below MAX_SIDE.
  localparam int SZW  = $clog2(MAX_SIDE + 1);
  localparam int AW   = $clog2(MAX_SIDE);
  localparam int PW   = 2 * SZW;
  localparam int CNTW = $clog2(PW + 1);
  localparam logic [SZW-1:0]  SIDE_MAX = SZW'(MAX_SIDE);
  localparam logic [SZW-1:0]  SIDE_ONE = SZW'(1);
  localparam logic [CNTW-1:0] DIV_BITS = CNTW'(PW);
  localparam logic [CNTW-1:0] CNT_ONE  = CNTW'(1);

  // ---------------------------------------------------------------------------------------
  // Configuration registers. They only feed the geometry sequencer, so a write in the middle
  // of a frame changes nothing until the next frame starts.
  // ---------------------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] cfg_source_width;
  logic [CFG_DATA_W-1:0] cfg_source_height;
  logic [CFG_DATA_W-1:0] cfg_target_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_source_width  <= RST_SOURCE_SIDE;
      cfg_source_height <= RST_SOURCE_SIDE;
      cfg_target_side   <= RST_TARGET_SIDE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  cfg_source_width  <= cfg_data;
        CFG_SOURCE_HEIGHT: cfg_source_height <= cfg_data;
        CFG_TARGET_SIDE:   cfg_target_side   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero side counts as one and anything above MAX_SIDE counts as MAX_SIDE.
  function automatic logic [SZW-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
    logic [SZW-1:0] r;
    if (v == '0) begin
      r = SIDE_ONE;
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      r = SIDE_MAX;
    end else begin
      r = SZW'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Geometry sequencer. It prepares the "pending" geometry that the next frame will use:
  //   out_width  = max(1, fw * te / m),  out_height = max(1, fh * te / m)
  //   col_step, col_frac = fw / out_width  (quotient and remainder), and the same for rows.
  // te is the target side, or m itself in passthrough, which makes the output size equal to
  // the source size without a separate path. One restoring divider, one quotient bit per
  // cycle, is shared by the four quotients.
  // ---------------------------------------------------------------------------------------
  geom_state_t geom_state;
  geom_state_t geom_state_next;
  geom_step_t  geom_step;

  logic geom_busy;
  logic clamp_en;
  logic div_load;
  logic div_run;
  logic div_last;

  logic [SZW-1:0] c_fw;
  logic [SZW-1:0] c_fh;
  logic [SZW-1:0] c_m;
  logic           c_pass;
  logic [SZW-1:0] c_te;

  logic [SZW-1:0] pend_fw;
  logic [SZW-1:0] pend_fh;
  logic [SZW-1:0] pend_m;
  logic [SZW-1:0] pend_te;
  logic [SZW-1:0] pend_ow;
  logic [SZW-1:0] pend_oh;
  logic [SZW-1:0] pend_col_step;
  logic [SZW-1:0] pend_col_frac;
  logic [SZW-1:0] pend_row_step;
  logic [SZW-1:0] pend_row_frac;

  logic [PW-1:0]   div_quo;
  logic [SZW-1:0]  div_rem;
  logic [SZW-1:0]  div_den;
  logic [CNTW-1:0] div_cnt;

  logic [SZW-1:0] mul_a;
  logic [PW-1:0]  mul_p;
  logic [PW-1:0]  load_num;
  logic [SZW-1:0] load_den;
  logic [SZW:0]   div_shift;
  logic           div_fit;
  logic [SZW-1:0] div_rem_next;
  logic [PW-1:0]  div_quo_next;
  logic [SZW-1:0] div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom_state <= G_CLAMP;
    end else begin
      geom_state <= geom_state_next;
    end
  end

  always_comb begin
    geom_state_next = geom_state;
    case (geom_state)
      G_IDLE:  geom_state_next = G_IDLE;
      G_CLAMP: geom_state_next = G_LOAD;
      G_LOAD:  geom_state_next = G_RUN;
      G_RUN: begin
        if (div_last) begin
          geom_state_next = (geom_step == STEP_CH) ? G_IDLE : G_LOAD;
        end
      end
      default: geom_state_next = G_IDLE;
    endcase
    // Any write restarts the computation from the new register values.
    if (cfg_write) begin
      geom_state_next = G_CLAMP;
    end
  end

  always_comb begin
    geom_busy = 1'b1;
    clamp_en  = 1'b0;
    div_load  = 1'b0;
    div_run   = 1'b0;
    case (geom_state)
      G_IDLE:  geom_busy = 1'b0;
      G_CLAMP: clamp_en  = 1'b1;
      G_LOAD:  div_load  = 1'b1;
      G_RUN:   div_run   = 1'b1;
      default: geom_busy = 1'b1;
    endcase
  end

  always_comb begin
    c_fw   = clamp_side(cfg_source_width);
    c_fh   = clamp_side(cfg_source_height);
    c_m    = (c_fw > c_fh) ? c_fw : c_fh;
    c_pass = (cfg_target_side == '0) || (32'(cfg_target_side) >= 32'(c_m));
    c_te   = c_pass ? c_m : SZW'(cfg_target_side);
  end

  // Divider operands for the current step. For the output-size steps the product lands in the dividend register.
  always_comb begin
    mul_a = (geom_step == STEP_OW) ? pend_fw : pend_fh;
    mul_p = mul_a * pend_te;
    case (geom_step)
      STEP_OW: begin
        load_num = mul_p;
        load_den = pend_m;
      end
      STEP_OH: begin
        load_num = mul_p;
        load_den = pend_m;
      end
      STEP_CW: begin
        load_num = PW'(pend_fw);
        load_den = pend_ow;
      end
      default: begin
        load_num = PW'(pend_fh);
        load_den = pend_oh;
      end
    endcase
  end

  // One shift-subtract step. The remainder stays below the divisor, so SZW bits hold it.
  always_comb begin
    div_shift    = {div_rem, div_quo[PW-1]};
    div_fit      = div_shift >= {1'b0, div_den};
    div_rem_next = div_fit ? SZW'(div_shift - {1'b0, div_den}) : div_shift[SZW-1:0];
    div_quo_next = {div_quo[PW-2:0], div_fit};
    div_q        = div_quo_next[SZW-1:0];
    div_last     = (div_cnt == CNT_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom_step <= STEP_OW;
      div_cnt   <= '0;
    end else if (clamp_en) begin
      geom_step <= STEP_OW;
    end else if (div_load) begin
      div_cnt <= DIV_BITS;
    end else if (div_run) begin
      div_cnt <= div_cnt - CNT_ONE;
      if (div_last) begin
        case (geom_step)
          STEP_OW: geom_step <= STEP_OH;
          STEP_OH: geom_step <= STEP_CW;
          STEP_CW: geom_step <= STEP_CH;
          default: geom_step <= STEP_OW;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clamp_en) begin
      pend_fw <= c_fw;
      pend_fh <= c_fh;
      pend_m  <= c_m;
      pend_te <= c_te;
    end
    if (div_load) begin
      div_quo <= load_num;
      div_rem <= '0;
      div_den <= load_den;
    end else if (div_run) begin
      div_quo <= div_quo_next;
      div_rem <= div_rem_next;
      if (div_last) begin
        case (geom_step)
          STEP_OW: pend_ow <= (div_q == '0) ? SIDE_ONE : div_q;
          STEP_OH: pend_oh <= (div_q == '0) ? SIDE_ONE : div_q;
          STEP_CW: begin
            pend_col_step <= div_q;
            pend_col_frac <= div_rem_next;
          end
          default: begin
            pend_row_step <= div_q;
            pend_row_frac <= div_rem_next;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 0: position tracking at request acceptance.
  // Window ends are floor(k * fw / ow). Stepping k by one adds col_step to the quotient and
  // col_frac to a running remainder; when the remainder reaches ow it wraps and the boundary
  // moves one further. The remainder that goes with the first boundary is col_frac itself.
  // Rows work the same way. The start of a window is the end of the one before it, so no
  // division happens per pixel.
  // On the first request of a frame (both positions zero) the pending geometry is taken,
  // and all per-frame values below come from it in that same cycle.
  // ---------------------------------------------------------------------------------------
  logic [AW-1:0]  source_col;
  logic [AW-1:0]  source_row;
  logic [AW-1:0]  window_col;
  logic [AW-1:0]  window_row;
  logic [SZW-1:0] col_start;
  logic [SZW-1:0] col_bound;
  logic [SZW-1:0] col_acc;
  logic [SZW-1:0] row_start;
  logic [SZW-1:0] row_bound;
  logic [SZW-1:0] row_acc;

  logic [SZW-1:0] fw;
  logic [SZW-1:0] fh;
  logic [SZW-1:0] ow;
  logic [SZW-1:0] oh;
  logic [SZW-1:0] col_step;
  logic [SZW-1:0] col_frac;
  logic [SZW-1:0] row_step;
  logic [SZW-1:0] row_frac;

  logic           frame_start;
  logic [SZW-1:0] e_fw;
  logic [SZW-1:0] e_fh;
  logic [SZW-1:0] e_ow;
  logic [SZW-1:0] e_oh;
  logic [SZW-1:0] e_col_step;
  logic [SZW-1:0] e_col_frac;
  logic [SZW-1:0] e_row_step;
  logic [SZW-1:0] e_row_frac;
  logic [AW-1:0]  e_wc;
  logic [AW-1:0]  e_wr;
  logic [SZW-1:0] e_col_start;
  logic [SZW-1:0] e_col_bound;
  logic [SZW-1:0] e_col_acc;
  logic [SZW-1:0] e_row_start;
  logic [SZW-1:0] e_row_bound;
  logic [SZW-1:0] e_row_acc;

  logic [SZW-1:0] col_p1;
  logic [SZW-1:0] row_p1;
  logic           first_px;
  logic           last_col;
  logic           last_row;
  logic           row_done;
  logic           frame_done;
  logic           win_row_end;
  logic           win_frame_end;
  logic           wr_wrap;

  logic [SZW:0]   c_sum;
  logic           c_wrap;
  logic [SZW-1:0] c_acc_adv;
  logic [SZW-1:0] c_bound_adv;
  logic [SZW:0]   r_sum;
  logic           r_wrap;
  logic [SZW-1:0] r_acc_adv;
  logic [SZW-1:0] r_bound_adv;

  logic in_acc;

  always_comb begin
    frame_start = (source_col == '0) && (source_row == '0);

    e_fw        = frame_start ? pend_fw       : fw;
    e_fh        = frame_start ? pend_fh       : fh;
    e_ow        = frame_start ? pend_ow       : ow;
    e_oh        = frame_start ? pend_oh       : oh;
    e_col_step  = frame_start ? pend_col_step : col_step;
    e_col_frac  = frame_start ? pend_col_frac : col_frac;
    e_row_step  = frame_start ? pend_row_step : row_step;
    e_row_frac  = frame_start ? pend_row_frac : row_frac;
    e_wc        = frame_start ? '0            : window_col;
    e_wr        = frame_start ? '0            : window_row;
    e_col_start = frame_start ? '0            : col_start;
    e_col_bound = frame_start ? pend_col_step : col_bound;
    e_col_acc   = frame_start ? pend_col_frac : col_acc;
    e_row_start = frame_start ? '0            : row_start;
    e_row_bound = frame_start ? pend_row_step : row_bound;
    e_row_acc   = frame_start ? pend_row_frac : row_acc;

    col_p1 = SZW'(source_col) + SIDE_ONE;
    row_p1 = SZW'(source_row) + SIDE_ONE;

    // The first pixel of a window seeds its running maximum instead of merging.
    first_px = (SZW'(source_row) == e_row_start) && (SZW'(source_col) == e_col_start);
    last_col = (col_p1 == e_col_bound);
    last_row = (row_p1 == e_row_bound);
    row_done   = (col_p1 == e_fw);
    frame_done = row_done && (row_p1 == e_fh);

    win_row_end   = ((SZW'(e_wc) + SIDE_ONE) == e_ow);
    wr_wrap       = ((SZW'(e_wr) + SIDE_ONE) == e_oh);
    win_frame_end = win_row_end && wr_wrap;

    // Next column boundary. Past the last window it is never used, since the row ends there.
    c_sum       = {1'b0, e_col_acc} + {1'b0, e_col_frac};
    c_wrap      = (c_sum >= {1'b0, e_ow});
    c_acc_adv   = c_wrap ? SZW'(c_sum - {1'b0, e_ow}) : c_sum[SZW-1:0];
    c_bound_adv = SZW'(e_col_bound + e_col_step + SZW'(c_wrap));

    r_sum       = {1'b0, e_row_acc} + {1'b0, e_row_frac};
    r_wrap      = (r_sum >= {1'b0, e_oh});
    r_acc_adv   = r_wrap ? SZW'(r_sum - {1'b0, e_oh}) : r_sum[SZW-1:0];
    r_bound_adv = SZW'(e_row_bound + e_row_step + SZW'(r_wrap));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_col <= '0;
      source_row <= '0;
      window_col <= '0;
      window_row <= '0;
      col_start  <= '0;
      col_bound  <= '0;
      col_acc    <= '0;
      row_start  <= '0;
      row_bound  <= '0;
      row_acc    <= '0;
    end else if (in_acc) begin
      if (row_done) begin
        // End of a source row: column tracking starts over with the first window.
        source_col <= '0;
        window_col <= '0;
        col_start  <= '0;
        col_bound  <= e_col_step;
        col_acc    <= e_col_frac;
        source_row <= frame_done ? '0 : source_row + AW'(1);
        if (last_row && wr_wrap) begin
          window_row <= '0;
          row_start  <= '0;
          row_bound  <= e_row_step;
          row_acc    <= e_row_frac;
        end else if (last_row) begin
          window_row <= e_wr + AW'(1);
          row_start  <= e_row_bound;
          row_bound  <= r_bound_adv;
          row_acc    <= r_acc_adv;
        end else begin
          window_row <= e_wr;
          row_start  <= e_row_start;
          row_bound  <= e_row_bound;
          row_acc    <= e_row_acc;
        end
      end else begin
        source_col <= source_col + AW'(1);
        window_row <= e_wr;
        row_start  <= e_row_start;
        row_bound  <= e_row_bound;
        row_acc    <= e_row_acc;
        if (last_col) begin
          window_col <= e_wc + AW'(1);
          col_start  <= e_col_bound;
          col_bound  <= c_bound_adv;
          col_acc    <= c_acc_adv;
        end else begin
          window_col <= e_wc;
          col_start  <= e_col_start;
          col_bound  <= e_col_bound;
          col_acc    <= e_col_acc;
        end
      end
    end
  end

  // Frame geometry is latched with the first request of the frame.
  always_ff @(posedge clk) begin
    if (in_acc && frame_start) begin
      fw       <= pend_fw;
      fh       <= pend_fh;
      ow       <= pend_ow;
      oh       <= pend_oh;
      col_step <= pend_col_step;
      col_frac <= pend_col_frac;
      row_step <= pend_row_step;
      row_frac <= pend_row_frac;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: read-modify-write of the column store, one entry per output column.
  // The read is issued on the edge that accepts the request. If the request ahead writes
  // the same entry on that same edge, the read would be stale, so its merged value is
  // carried along instead. Requests further ahead have already written.
  // ---------------------------------------------------------------------------------------
  logic             s1_valid;
  logic [PIX_W-1:0] s1_value;
  logic             s1_first;
  logic             s1_emit;
  logic             s1_row_end;
  logic             s1_frame_end;
  logic [AW-1:0]    s1_idx;
  logic             s1_fwd;
  logic [PIX_W-1:0] s1_fwd_value;

  logic [PIX_W-1:0] ram_rd_data;
  logic [PIX_W-1:0] s1_base;
  logic [PIX_W-1:0] s1_held;
  logic             s1_go;

  always_comb begin
    s1_base = s1_fwd ? s1_fwd_value : ram_rd_data;
    if (s1_first) begin
      s1_held = s1_value;
    end else begin
      s1_held = (s1_value > s1_base) ? s1_value : s1_base;
    end
    // Stage 1 only waits when it has a result and the output register cannot take it.
    s1_go    = s1_valid && (!s1_emit || !out_valid || !out_stall);
    in_stall = rst || geom_busy || (s1_valid && !s1_go);
    in_acc   = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value     <= elevation;
      s1_first     <= first_px;
      s1_emit      <= last_col && last_row;
      s1_row_end   <= win_row_end;
      s1_frame_end <= win_frame_end;
      s1_idx       <= e_wc;
      s1_fwd       <= s1_go && (s1_idx == e_wc);
      s1_fwd_value <= s1_held;
    end
  end

  mpd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SIDE)
  ) u_column_maxima (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_idx),
    .wr_data (s1_held),
    .rd_en   (in_acc),
    .rd_addr (e_wc),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------------------
  // Output register. It decouples the two sides: stage 1 refills it on the same edge at
  // which the downstream side takes the previous result.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      pooled_value <= s1_held;
      row_end      <= s1_row_end;
      frame_end    <= s1_frame_end;
    end
  end

endmodule

>>> sv/mpd_checker.sv
// Port-level checker for the downsampler and the bind that attaches it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpd_checker (
  input logic clk,
  input logic rst,
  input logic cfg_write,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic row_end,
  input logic frame_end
);

  // The last pixel of a frame is always the last pixel of its row too.
  `MPD_ASSERT(a_frame_end_on_row_end, clk, rst, out_valid |-> (!frame_end || row_end), "frame_end without row_end")

  // Reset empties the output register.
  `MPD_ASSERT_ALWAYS(a_reset_clears_output, clk, rst |=> !out_valid, "result valid after reset")

  // A register write starts a geometry update, which holds off new requests.
  `MPD_ASSERT(a_write_holds_input, clk, rst, cfg_write |=> in_stall, "request taken during geometry update")

  // A result that appears on an empty output came from a request that passed through stage 1 without waiting.
  `MPD_ASSERT(a_result_has_source, clk, rst, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without a request")

endmodule

bind max_pool_downsampler mpd_checker u_mpd_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for max_pool_downsampler against a window-maximum predictor.
`timescale 1ns / 1ps

// Line-store depth of the block under test. The instance below uses it as MAX_SIDE.
localparam int unsigned SIDE_LIMIT = 4096;

// Frame side as the block sees it. A zero counts as one, and anything above the
// line-store depth counts as the full depth.
function automatic int unsigned side_of(input logic [12:0] reg_value);
  if (reg_value == 0) return 1;
  if (reg_value > SIDE_LIMIT) return SIDE_LIMIT;
  return 32'(reg_value);
endfunction

// Tracks the pooling geometry, predicts the pooled output stream and checks the
// block's results against it in order.
class pooled_scoreboard;
  typedef struct packed {
    logic [mpd_pkg::PIX_W-1:0] value;
    logic                      last_in_row;
    logic                      last_in_frame;
  } pooled_t;

  // Past this many failures the run keeps counting but stops printing.
  localparam int unsigned REPORT_CAP = 100;

  logic [mpd_pkg::PIX_W-1:0]      col_max [SIDE_LIMIT];
  logic [mpd_pkg::CFG_DATA_W-1:0] reg_w, reg_h, reg_t;
  int unsigned src_col, src_row, win_col, win_row;
  int unsigned col_bound, row_bound, out_w, out_h, fr_w, fr_h;
  pooled_t     pending[$];
  int unsigned mismatches;

  function new();
    reg_w      = mpd_pkg::RST_SOURCE_SIDE;
    reg_h      = mpd_pkg::RST_SOURCE_SIDE;
    reg_t      = mpd_pkg::RST_TARGET_SIDE;
    src_col    = 0;
    src_row    = 0;
    win_col    = 0;
    win_row    = 0;
    col_bound  = 1;
    row_bound  = 1;
    out_w      = 1;
    out_h      = 1;
    fr_w       = 1;
    fr_h       = 1;
    mismatches = 0;
  endfunction

  function void write_reg(input logic [mpd_pkg::CFG_IDX_W-1:0] index,
                          input logic [mpd_pkg::CFG_DATA_W-1:0] data);
    case (index)
      mpd_pkg::CFG_SOURCE_WIDTH:  reg_w = data;
      mpd_pkg::CFG_SOURCE_HEIGHT: reg_h = data;
      mpd_pkg::CFG_TARGET_SIDE:   reg_t = data;
      default: ;
    endcase
  endfunction

  function void take_sample(input logic [mpd_pkg::PIX_W-1:0] sample);
    int unsigned span, col_first, row_first, slot;
    logic [mpd_pkg::PIX_W-1:0] peak;
    bit close_col, close_row, close_line;
    pooled_t item;
    // The registers only matter at the first pixel of a frame.
    if (src_col == 0 && src_row == 0) begin
      fr_w = side_of(reg_w);
      fr_h = side_of(reg_h);
      span = (fr_w > fr_h) ? fr_w : fr_h;
      if (reg_t == 0 || reg_t >= span) begin
        out_w = fr_w;
        out_h = fr_h;
      end else begin
        out_w = (fr_w * reg_t) / span;
        out_h = (fr_h * reg_t) / span;
        if (out_w == 0) out_w = 1;
        if (out_h == 0) out_h = 1;
      end
      win_col   = 0;
      win_row   = 0;
      col_bound = fr_w / out_w;
      row_bound = fr_h / out_h;
    end
    col_first = (win_col * fr_w) / out_w;
    row_first = (win_row * fr_h) / out_h;
    slot      = (win_col < SIDE_LIMIT) ? win_col : SIDE_LIMIT - 1;
    // The first pixel of a window starts its running maximum afresh.
    if (src_row == row_first && src_col == col_first) begin
      peak = sample;
    end else begin
      peak = col_max[slot];
      if (sample > peak) peak = sample;
    end
    col_max[slot] = peak;

    close_col  = (src_col + 1 == col_bound);
    close_row  = (src_row + 1 == row_bound);
    close_line = (win_col + 1 == out_w);
    if (close_col && close_row) begin
      item.value         = peak;
      item.last_in_row   = close_line;
      item.last_in_frame = close_line && (win_row + 1 == out_h);
      pending.push_back(item);
    end
    if (close_col) begin
      win_col   = close_line ? 0 : win_col + 1;
      col_bound = ((win_col + 1) * fr_w) / out_w;
    end
    src_col++;
    if (src_col >= fr_w) begin
      src_col   = 0;
      win_col   = 0;
      col_bound = fr_w / out_w;
      if (close_row) begin
        win_row   = (win_row + 1 == out_h) ? 0 : win_row + 1;
        row_bound = ((win_row + 1) * fr_h) / out_h;
      end
      src_row++;
      if (src_row >= fr_h) src_row = 0;
    end
  endfunction

  function void check_pooled(input logic [mpd_pkg::PIX_W-1:0] value,
                             input logic last_in_row, input logic last_in_frame);
    pooled_t got, want;
    got = {value, last_in_row, last_in_frame};
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: unexpected result: expected none, got value %h row_end %b frame_end %b",
                 $time, value, last_in_row, last_in_frame);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: expected value %h row_end %b frame_end %b, got value %h row_end %b frame_end %b",
                 $time, want.value, want.last_in_row, want.last_in_frame,
                 value, last_in_row, last_in_frame);
    end
  endfunction

  function int unsigned outstanding();
    return pending.size();
  endfunction
endclass

module tb_top;
  import mpd_pkg::*;

  // Index 3 has no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Cycles without any accepted request, taken result or register write
  // before the run is declared hung. The longest honest quiet spell is one
  // geometry recomputation plus a long receiver stall.
  localparam int unsigned QUIET_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      elevation;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      pooled_value;
  logic                  row_end;
  logic                  frame_end;

  pooled_scoreboard sb = new();

  // Idle and stall odds, in percent, of the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Source size most recently written, and the pixels left in the frame that
  // the block is currently working through.
  logic [CFG_DATA_W-1:0] next_w = RST_SOURCE_SIDE;
  logic [CFG_DATA_W-1:0] next_h = RST_SOURCE_SIDE;
  int unsigned frame_left = 0;
  int unsigned samples_sent = 0;
  int unsigned quiet_cycles = 0;

  // A 4x3 frame pooled to 2x1: the two windows hold the all-zero and all-one
  // extremes, single-bit patterns and values that differ only in the low bit.
  logic [PIX_W-1:0] corners [12] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
    16'h7FFF, 16'h0000, 16'hFFFE, 16'h1234,
    16'h0000, 16'h0000, 16'h5555, 16'hAAAA
  };

  max_pool_downsampler #(
    .MAX_SIDE(SIDE_LIMIT)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .elevation   (elevation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pooled_value(pooled_value),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

  always #4 clk = ~clk;

  // The receiver stalls at random with the odds of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor and watchdog. Everything here is sampled at the clock edge, before
  // any register of the block or any driver of this bench has moved, so the
  // order of processes within the edge does not matter. A result is checked
  // before a request at the same edge is noted; the result always belongs to
  // an earlier request anyway.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) sb.check_pooled(pooled_value, row_end, frame_end);
      if (in_valid && !in_stall) sb.take_sample(elevation);
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_write) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("** max_pool_downsampler: FAILED **");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Writes all three geometry registers on consecutive edges. Only called
  // while nothing is in flight.
  task automatic program_geometry(input logic [CFG_DATA_W-1:0] w, h, t);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_TARGET_SIDE;
    cfg_data  <= t;
    @(posedge clk);
    cfg_write <= 1'b0;
    next_w = w;
    next_h = h;
  endtask

  // Presents one sample, after a random idle gap, and holds it until the
  // request is taken. Valid is left high so back-to-back requests need no
  // second assignment in the same step.
  task automatic push_sample(input logic [PIX_W-1:0] sample);
    if (frame_left == 0) frame_left = side_of(next_w) * side_of(next_h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    elevation <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_left--;
    samples_sent++;
  endtask

  // Mostly uniform samples, with the extremes and tiny values mixed in so that
  // ties and near-ties inside a window are common.
  function automatic logic [PIX_W-1:0] rand_elevation();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(15));
      default: return PIX_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_pixels(input int unsigned count);
    repeat (count) push_sample(rand_elevation());
  endtask

  // Drops valid and waits until every expected result has come back. The
  // first edge lets the monitor note the last request; the extra cycles cover
  // the column-store writes of requests that close no window.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly small sides, sometimes a zero, sometimes a mid-size one.
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(40, 13));
      default: return CFG_DATA_W'($urandom_range(12, 1));
    endcase
  endfunction

  // Random geometries, each followed by a random run of pixels that may end
  // anywhere in a frame. A quarter of the time the next geometry is written
  // while a frame is still open, so the old geometry must carry on to its end.
  // No run goes past the phase's quota.
  task automatic random_phase(input int unsigned quota);
    int unsigned first, span, left, count;
    logic [CFG_DATA_W-1:0] w, h, t;
    first = samples_sent;
    while (samples_sent - first < quota) begin
      left = quota - (samples_sent - first);
      if ($urandom_range(3) != 0) send_pixels((frame_left < left) ? frame_left : left);
      w    = pick_side();
      h    = pick_side();
      span = (side_of(w) > side_of(h)) ? side_of(w) : side_of(h);
      case ($urandom_range(7))
        0:       t = '0;
        1:       t = CFG_DATA_W'(span);
        2:       t = CFG_DATA_W'($urandom_range(8191, span));
        default: t = CFG_DATA_W'($urandom_range(span, 1));
      endcase
      settle();
      program_geometry(w, h, t);
      left  = quota - (samples_sent - first);
      count = $urandom_range(2 * side_of(w) * side_of(h), 1);
      send_pixels((count < left) ? count : left);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    elevation <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side.
    // Pooling with both window columns holding the corner values.
    program_geometry(13'd4, 13'd3, 13'd2);
    foreach (corners[i]) push_sample(corners[i]);

    // Zero sizes count as one pixel: every sample is a whole frame.
    settle();
    program_geometry(13'd0, 13'd0, 13'd5);
    push_sample(16'hFFFF);
    push_sample(16'h0000);

    // A new geometry written one pixel into a 3x1 passthrough frame must wait
    // for that frame to finish; the 2x2 frame after it pools to one pixel.
    settle();
    program_geometry(13'd3, 13'd1, 13'd0);
    push_sample(16'hABCD);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= 13'h1FFF;
    @(posedge clk);
    cfg_write <= 1'b0;
    program_geometry(13'd2, 13'd2, 13'd1);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_sample(16'h00FF);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h0000);

    // A target far above the larger side falls back to passthrough.
    settle();
    program_geometry(13'd2, 13'd1, 13'd4096);
    push_sample(16'h4321);
    push_sample(16'hFFFF);

    // Random part, one phase per idling pattern.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(260);
    send_idle_pct = 49;
    recv_idle_pct = 0;
    random_phase(260);
    send_idle_pct = 0;
    recv_idle_pct = 49;
    random_phase(260);
    send_idle_pct = 34;
    recv_idle_pct = 34;
    random_phase(260);

    // Full-depth frame: an oversized width clamped to the line store and
    // pooled to 100 columns of uneven width. Only the start of the row is
    // sent, which closes several windows.
    send_pixels(frame_left);
    settle();
    program_geometry(13'h1FFF, 13'd1, 13'd100);
    send_pixels(330);

    settle();
    if (sb.mismatches == 0) begin
      $display("** max_pool_downsampler: PASSED **");
    end else begin
      $display("** max_pool_downsampler: FAILED **");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/mpd_pkg.sv
sv/mpd_ram.sv
sv/max_pool_downsampler.sv
sv/mpd_checker.sv
tb/sv/tb_top.sv
